// File: hw/rtl/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 instruction executor.
// No dependencies.
package c8ie_pkg;

  typedef struct packed {
    logic        opcode;
    logic [15:0] instruction_word;
    logic [3:0]  load_index;
    logic [7:0]  load_data;
    logic [15:0] keys_pressed;
    logic        key_ready;
    logic [3:0]  key_code;
    logic [7:0]  delay_now;
    logic [7:0]  random_byte;
  } in_word_t;

  typedef struct packed {
    logic [11:0] next_fetch;
    logic        write_strobe;
    logic        read_strobe;
    logic [11:0] mem_address;
    logic [7:0]  mem_byte;
    logic        delay_load;
    logic        sound_load;
    logic [7:0]  timer_value;
    logic        illegal;
    logic        key_wait;
    logic        final_result;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_HOLD
  } state_e;

  // Result kinds the datapath can form in one emit step.
  typedef enum logic [1:0] {
    RK_PLAIN,
    RK_BCD,
    RK_SAVE,
    RK_LOAD
  } res_kind_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic capture;   // latch a new input word
    logic execute;   // run the latched instruction, update state
    logic emit;      // load the output register with the current result
    logic advance;   // step the result counter
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic last;      // current result is the final one
  } dp_sts_t;

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [7:0]  FX_DELAY_R = 8'h07;
  localparam logic [7:0]  FX_KEY     = 8'h0A;
  localparam logic [7:0]  FX_DELAY_W = 8'h15;
  localparam logic [7:0]  FX_SOUND_W = 8'h18;
  localparam logic [7:0]  FX_ADD_I   = 8'h1E;
  localparam logic [7:0]  FX_FONT    = 8'h29;
  localparam logic [7:0]  FX_BCD     = 8'h33;
  localparam logic [7:0]  FX_SAVE    = 8'h55;
  localparam logic [7:0]  FX_LOAD    = 8'h65;
  localparam logic [7:0]  EX_SKP     = 8'h9E;
  localparam logic [7:0]  EX_SKNP    = 8'hA1;
  localparam logic [11:0] SYS_RET    = 12'h0EE;

endpackage

// File: hw/rtl/chip8_instruction_executor_top.sv
// CHIP-8 instruction executor. Each input word is an instruction or a returned
// load byte; the block answers with one or more result words, the last marked by
// final_result. An item goes through capture, execute, stack read and result
// formation before its first result; further results follow, one per handoff,
// walked by the single controller that steps the result counter; register
// save and load give X+1 results, BCD three, everything else one. A new word is
// taken in the same cycle the final result is handed off.
// Depends on c8ie_pkg, c8ie_ctrl, c8ie_dp and c8ie_ram.
module chip8_instruction_executor_top import c8ie_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  c8ie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  c8ie_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_word_o(out_data_o)
  );
endmodule

// File: hw/rtl/c8ie_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module c8ie_ram #(
  parameter int Width = 12,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hw/rtl/c8ie_ctrl.sv
// Controller state machine for the CHIP-8 instruction executor.
// Depends on c8ie_pkg.
module c8ie_ctrl import c8ie_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // the stack read data is valid here
        cmd_o.emit = 1'b1;
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.last) begin
            // overlap acceptance of the next word with the last handoff
            in_stall_o = 1'b0;
            if (in_valid_i) begin
              cmd_o.capture = 1'b1;
              state_d = ST_EXEC;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            cmd_o.advance = 1'b1;
            cmd_o.emit    = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/c8ie_dp.sv
// Datapath: register file, index, PC, return stack and result formation.
// Depends on c8ie_pkg and c8ie_ram.
module c8ie_dp import c8ie_pkg::*; #(
  parameter int StackDepth = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_word_t out_word_o
);
  localparam int SpW = $clog2(StackDepth);
  localparam int LvW = $clog2(StackDepth + 1);
  localparam logic [LvW-1:0] LvMax = LvW'(StackDepth);

  in_word_t in_q;
  logic [7:0]  v_q [16];
  logic [7:0]  v_d [16];
  logic [15:0] i_q, i_d;
  logic [11:0] pc_q, pc_d;
  logic [LvW-1:0] lvl_q, lvl_d;
  logic        wait_q, wait_d;
  logic [3:0]  tgt_q, tgt_d;

  // per-item result plan
  res_kind_e   kind_q, kind_d;
  logic        ill_q, ill_d;
  logic        dl_q, dl_d, sl_q, sl_d;
  logic [7:0]  tv_q, tv_d;
  logic [3:0]  cnt_q, last_q, last_d;
  logic [7:0]  bcd_q [3];
  logic [7:0]  bcd_d [3];
  logic        ret_q, ret_d;
  out_word_t   out_q;
  out_word_t   res_d;

  // stack
  logic           st_we;
  logic [SpW-1:0] st_waddr, st_raddr;
  logic [11:0]    st_rdata;

  logic [15:0] w;
  logic [3:0]  x, y;
  logic [7:0]  kk, vx, vy, v0;
  logic [11:0] nnn, pc2, pc4;
  logic [8:0]  sum9;
  logic        key;
  logic [6:0]  tens_all;
  logic [3:0]  hund;
  logic [7:0]  rem100;

  // push the return address, the word after the call
  c8ie_ram #(.Width(12), .Depth(StackDepth)) u_stack (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(pc2),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  always_comb begin
    w   = in_q.instruction_word;
    x   = w[11:8];
    y   = w[7:4];
    kk  = w[7:0];
    nnn = w[11:0];
    for (int k = 0; k < 16; k++) v_d[k] = v_q[k];
    i_d    = i_q;
    pc_d   = pc_q;
    lvl_d  = lvl_q;
    wait_d = wait_q;
    tgt_d  = tgt_q;
    kind_d = RK_PLAIN;
    ill_d  = 1'b0;
    dl_d   = 1'b0;
    sl_d   = 1'b0;
    tv_d   = '0;
    last_d = '0;
    ret_d  = 1'b0;
    st_we  = 1'b0;
    st_waddr = lvl_q[SpW-1:0];
    st_raddr = SpW'(lvl_q - LvW'(1));
    vx = '0; vy = '0; v0 = '0; pc2 = '0; pc4 = '0; sum9 = '0; key = 1'b0;
    // BCD hundreds digit by compare-subtract
    hund = '0; rem100 = '0; tens_all = '0;
    for (int k = 0; k < 3; k++) bcd_d[k] = bcd_q[k];

    if (in_q.opcode) begin
      v_d[in_q.load_index] = in_q.load_data;
    end else if (wait_q && !in_q.key_ready) begin
      // stalled on key: nothing changes
    end else begin
      if (wait_q) begin
        v_d[tgt_q] = {4'd0, in_q.key_code};
        wait_d = 1'b0;
      end
      vx  = v_d[x];
      vy  = v_d[y];
      v0  = v_d[0];
      pc2 = pc_q + 12'd2;
      pc4 = pc_q + 12'd4;
      pc_d = pc2;
      unique case (w[15:12])
        4'h0: begin
          if (nnn == SYS_RET) begin
            if (lvl_q == '0) begin
              ill_d = 1'b1;
            end else begin
              lvl_d = lvl_q - LvW'(1);
              ret_d = 1'b1;  // pc comes from the stack next cycle
            end
          end
        end
        4'h1: pc_d = nnn;
        4'h2: begin
          if (lvl_q >= LvMax) begin
            ill_d = 1'b1;
          end else begin
            st_we = 1'b1;
            lvl_d = lvl_q + LvW'(1);
            pc_d  = nnn;
          end
        end
        4'h3: if (vx == kk) pc_d = pc4;
        4'h4: if (vx != kk) pc_d = pc4;
        4'h5: if (vx == vy) pc_d = pc4;
        4'h6: v_d[x] = kk;
        4'h7: v_d[x] = vx + kk;
        4'h8: begin
          unique case (w[3:0])
            4'h0: v_d[x] = vy;
            4'h1: v_d[x] = vx | vy;
            4'h2: v_d[x] = vx & vy;
            4'h3: v_d[x] = vx ^ vy;
            4'h4: begin
              sum9 = {1'b0, vx} + {1'b0, vy};
              v_d[x] = sum9[7:0];
              v_d[15] = {7'd0, sum9[8]};
            end
            4'h5: begin
              v_d[x] = vx - vy;
              v_d[15] = {7'd0, vx >= vy};
            end
            4'h6: begin
              v_d[x] = {1'b0, vx[7:1]};
              v_d[15] = {7'd0, vx[0]};
            end
            4'h7: begin
              v_d[x] = vy - vx;
              v_d[15] = {7'd0, vy >= vx};
            end
            4'hE: begin
              v_d[x] = {vx[6:0], 1'b0};
              v_d[15] = {7'd0, vx[7]};
            end
            default: ill_d = 1'b1;
          endcase
        end
        4'h9: if (vx != vy) pc_d = pc4;
        4'hA: i_d = {4'd0, nnn};
        4'hB: pc_d = nnn + {4'd0, v0};
        4'hC: v_d[x] = in_q.random_byte & kk;
        4'hD: ;
        4'hE: begin
          key = (vx[7:4] == 4'd0) ? in_q.keys_pressed[vx[3:0]] : 1'b0;
          if (kk == EX_SKP) begin
            if (key) pc_d = pc4;
          end else if (kk == EX_SKNP) begin
            if (!key) pc_d = pc4;
          end else begin
            ill_d = 1'b1;
          end
        end
        4'hF: begin
          unique case (kk)
            FX_DELAY_R: v_d[x] = in_q.delay_now;
            FX_KEY: begin
              wait_d = 1'b1;
              tgt_d  = x;
            end
            FX_DELAY_W: begin
              dl_d = 1'b1;
              tv_d = vx;
            end
            FX_SOUND_W: begin
              sl_d = 1'b1;
              tv_d = vx;
            end
            FX_ADD_I: i_d = i_q + {8'd0, vx};
            FX_FONT:  i_d = {8'd0, vx} * 16'd5;
            FX_BCD: begin
              kind_d = RK_BCD;
              last_d = 4'd2;
              if (vx >= 8'd200) begin
                hund = 4'd2; rem100 = vx - 8'd200;
              end else if (vx >= 8'd100) begin
                hund = 4'd1; rem100 = vx - 8'd100;
              end else begin
                hund = 4'd0; rem100 = vx;
              end
              // divide by ten via reciprocal multiply (rem100 < 100)
              tens_all = 7'((16'(rem100) * 16'd205) >> 11);
              bcd_d[0] = {4'd0, hund};
              bcd_d[1] = {1'b0, tens_all};
              bcd_d[2] = rem100 - 8'(tens_all * 7'd10);
            end
            FX_SAVE: begin
              kind_d = RK_SAVE;
              last_d = x;
            end
            FX_LOAD: begin
              kind_d = RK_LOAD;
              last_d = x;
            end
            default: ill_d = 1'b1;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
      i_q    <= '0;
      pc_q   <= PC_RESET;
      lvl_q  <= '0;
      wait_q <= 1'b0;
      tgt_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.execute) begin
        for (int k = 0; k < 16; k++) v_q[k] <= v_d[k];
        i_q    <= i_d;
        pc_q   <= pc_d;
        lvl_q  <= lvl_d;
        wait_q <= wait_d;
        tgt_q  <= tgt_d;
        cnt_q  <= '0;
      end else begin
        if (cmd_i.emit && ret_q) begin
          pc_q <= st_rdata;
        end
        if (cmd_i.advance) begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_word_i;
    end
    if (cmd_i.execute) begin
      kind_q <= kind_d;
      ill_q  <= ill_d;
      dl_q   <= dl_d;
      sl_q   <= sl_d;
      tv_q   <= tv_d;
      last_q <= last_d;
      ret_q  <= ret_d;
      for (int k = 0; k < 3; k++) bcd_q[k] <= bcd_d[k];
    end
    if (cmd_i.emit) begin
      out_q <= res_d;
    end
  end

  // result formation; on advance the formed word is one ahead of the counter
  logic [3:0]  idx;
  logic [11:0] pc_now;
  always_comb begin
    idx    = cmd_i.advance ? cnt_q + 4'd1 : cnt_q;
    pc_now = ret_q ? st_rdata : pc_q;
    res_d  = '0;
    res_d.next_fetch   = pc_now;
    res_d.key_wait     = wait_q;
    res_d.final_result = (idx == last_q);
    unique case (kind_q)
      RK_PLAIN: begin
        res_d.illegal     = ill_q;
        res_d.delay_load  = dl_q;
        res_d.sound_load  = sl_q;
        res_d.timer_value = tv_q;
      end
      RK_BCD: begin
        res_d.write_strobe = 1'b1;
        res_d.mem_address  = i_q[11:0] + {8'd0, idx};
        res_d.mem_byte     = bcd_q[idx[1:0] == 2'd3 ? 2'd2 : idx[1:0]];
      end
      RK_SAVE: begin
        res_d.write_strobe = 1'b1;
        res_d.mem_address  = i_q[11:0] + {8'd0, idx};
        res_d.mem_byte     = v_q[idx];
      end
      RK_LOAD: begin
        res_d.read_strobe = 1'b1;
        res_d.mem_address = i_q[11:0] + {8'd0, idx};
      end
      default: ;
    endcase
  end

  assign sts_o.last = out_q.final_result;
  assign out_word_o = out_q;
endmodule
